@@ rtl/kpl_pkg.sv @@
`default_nettype none
package kpl_pkg;

  localparam logic [1:0] ACT_PAIR  = 2'd0;
  localparam logic [1:0] ACT_DESC  = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam int CFG_W      = 4;
  localparam int SLOT_W     = 12;
  localparam int GLYPH_W    = 16;
  localparam int VAL_W      = 16;
  localparam int COV_W      = 16;
  localparam int CNT_W      = 13;
  localparam int SEL_W      = 4;
  localparam int PROBE_W    = 14;
  localparam int PROBE_MAX  = 12285;
  localparam int ENTRY_W    = 48;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [GLYPH_W-1:0] left_glyph;
    logic [GLYPH_W-1:0] right_glyph;
    logic [VAL_W-1:0]   pair_value;
    logic [COV_W-1:0]   coverage_word;
    logic [SLOT_W-1:0]  first_pair;
    logic [CNT_W-1:0]   pair_count;
    logic [15:0]        search_range_bytes;
    logic [SEL_W-1:0]   selector_log;
    logic [15:0]        range_shift_bytes;
  } kpl_item_t;

  typedef struct packed {
    logic cap;
    logic red_load;
    logic red_step;
    logic direct;
    logic ram_wr;
    logic ram_rd;
    logic desc_wr;
    logic sub_next;
    logic srch_init;
    logic mid_load;
    logic srch_upd;
    logic acc;
    logic acc_hit;
    logic out_load;
  } kpl_cmd_t;

  typedef struct packed {
    logic red_done;
    logic bad;
    logic sub_end;
    logic sub_use;
    logic srch_open;
    logic key_eq;
  } kpl_sts_t;

endpackage
`default_nettype wire

@@ rtl/kpl_ram.sv @@
`default_nettype none
module kpl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

@@ rtl/kpl_ctrl.sv @@
`default_nettype none
module kpl_ctrl #(
  parameter bit DIRECT_ADDR = 1'b1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic [1:0]       in_action,
  output logic                  in_tready,
  input  wire logic             out_tready,
  output logic                  out_tvalid,
  input  wire kpl_pkg::kpl_sts_t sts,
  output kpl_pkg::kpl_cmd_t     cmd
);
  import kpl_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_DESC = 3'd2;
  localparam logic [2:0] S_SUB  = 3'd3;
  localparam logic [2:0] S_SRCH = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       wmode_r, wmode_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    wmode_nxt = wmode_r;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          wmode_nxt = (in_action == ACT_PAIR);
          case (in_action)
            ACT_PAIR:  state_nxt = S_RED;
            ACT_DESC:  state_nxt = S_DESC;
            ACT_QUERY: state_nxt = S_SUB;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_RED: begin
        if (sts.red_done) begin
          if (wmode_r) begin
            cmd.ram_wr = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            cmd.ram_rd = 1'b1;
            state_nxt  = S_CMP;
          end
        end else begin
          cmd.red_step = 1'b1;
        end
      end
      S_DESC: begin
        cmd.desc_wr = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_SUB: begin
        if (sts.bad || sts.sub_end) begin
          state_nxt = S_DONE;
        end else if (!sts.sub_use) begin
          cmd.sub_next = 1'b1;
        end else begin
          cmd.srch_init = 1'b1;
          state_nxt     = S_SRCH;
        end
      end
      S_SRCH: begin
        if (!sts.srch_open) begin
          cmd.acc      = 1'b1;
          cmd.sub_next = 1'b1;
          state_nxt    = S_SUB;
        end else begin
          cmd.mid_load = 1'b1;
          if (DIRECT_ADDR) begin
            cmd.direct = 1'b1;
            cmd.ram_rd = 1'b1;
            state_nxt  = S_CMP;
          end else begin
            cmd.red_load = 1'b1;
            state_nxt    = S_RED;
          end
        end
      end
      S_CMP: begin
        if (sts.key_eq) begin
          cmd.acc      = 1'b1;
          cmd.acc_hit  = 1'b1;
          cmd.sub_next = 1'b1;
          state_nxt    = S_SUB;
        end else begin
          cmd.srch_upd = 1'b1;
          state_nxt    = S_SRCH;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wmode_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wmode_r     <= wmode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
endmodule
`default_nettype wire

@@ rtl/kpl_dp.sv @@
`default_nettype none
module kpl_dp #(
  parameter int PAIR_DEPTH    = 4096,
  parameter int MAX_SUBTABLES = 8,
  parameter int RED_STEPS     = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire kpl_pkg::kpl_item_t          item,
  input  wire logic                        cfg_we,
  input  wire logic [kpl_pkg::CFG_W-1:0]   cfg_data,
  input  wire kpl_pkg::kpl_cmd_t           cmd,
  output kpl_pkg::kpl_sts_t                sts,
  output logic [kpl_pkg::OUT_DATA_W-1:0]   kerning,
  output logic                             bad_glyph
);
  import kpl_pkg::*;

  localparam int PW  = $clog2(PAIR_DEPTH);
  localparam int SW  = (MAX_SUBTABLES > 1) ? $clog2(MAX_SUBTABLES) : 1;
  localparam int SIW = $clog2(MAX_SUBTABLES + 1);
  localparam int RCW = $clog2(RED_STEPS + 2);

  logic [CFG_W-1:0]   cfg_count_r;
  kpl_item_t          it_r;
  logic [31:0]        key_r;
  logic               bad_r;
  logic [VAL_W-1:0]   sum_r;
  logic [SIW-1:0]     sub_idx_r;
  logic signed [14:0] lo_r, hi_r;
  logic [PROBE_W-1:0] mid_r;
  logic [PROBE_W-1:0] red_r;
  logic [RCW-1:0]     red_cnt_r;
  logic [VAL_W-1:0]   kern_r;
  logic               kbad_r;

  logic               d_use_r   [MAX_SUBTABLES];
  logic               d_ovr_r   [MAX_SUBTABLES];
  logic [SLOT_W-1:0]  d_first_r [MAX_SUBTABLES];
  logic [CNT_W-1:0]   d_cnt_r   [MAX_SUBTABLES];

  logic [SW-1:0]      cur;
  logic [4:0]         n_cfg, n_max, n_eff;
  logic [PROBE_W-1:0] mid_c, raw_c;
  logic [31:0]        addr_w;
  logic [PW-1:0]      ram_addr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [RCW-1:0]     red_k;
  logic [31:0]        red_sub;
  logic               red_ge;

  logic [15:0]        pw;
  logic [17:0]        sr6;
  logic [CNT_W-1:0]   diff;
  logic [15:0]        diff6;
  logic               sane, usable;
  logic [VAL_W-1:0]   acc_v;

  assign cur   = sub_idx_r[SW-1:0];
  assign n_cfg = 5'(cfg_count_r);
  assign n_max = 5'(MAX_SUBTABLES);
  assign n_eff = (n_cfg > n_max) ? n_max : n_cfg;

  assign mid_c  = PROBE_W'(({1'b0, lo_r[13:0]} + {1'b0, hi_r[13:0]}) >> 1);
  assign raw_c  = PROBE_W'(d_first_r[cur]) + mid_c;
  assign addr_w = cmd.direct ? 32'(raw_c) : 32'(red_r);
  assign ram_addr = addr_w[PW-1:0];

  assign red_k   = red_cnt_r - RCW'(1);
  assign red_sub = 32'(PAIR_DEPTH) << red_k;
  assign red_ge  = 32'(red_r) >= red_sub;

  // A header is sane only when the search range is six times a power of two,
  // so the pair count of the range is that power of two.
  assign pw    = 16'd1 << it_r.selector_log;
  assign sr6   = 18'd6 << it_r.selector_log;
  assign diff  = it_r.pair_count - pw[CNT_W-1:0];
  assign diff6 = 16'({diff, 2'b00}) + 16'({diff, 1'b0});
  assign sane  = (it_r.pair_count != '0) && ({2'b00, it_r.search_range_bytes} == sr6)
               && (pw <= 16'(it_r.pair_count)) && (diff6 == it_r.range_shift_bytes);
  assign usable = sane && it_r.coverage_word[0] && !it_r.coverage_word[1]
               && !it_r.coverage_word[2] && (it_r.coverage_word[15:4] == '0);

  assign acc_v = cmd.acc_hit ? ram_rdata[VAL_W-1:0] : '0;

  kpl_ram #(.WIDTH(ENTRY_W), .DEPTH(PAIR_DEPTH)) u_pairs (
    .clk   (clk),
    .we    (cmd.ram_wr),
    .re    (cmd.ram_rd),
    .addr  (ram_addr),
    .wdata ({it_r.left_glyph, it_r.right_glyph, it_r.pair_value}),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= '0;
    end else if (cfg_we) begin
      cfg_count_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      it_r      <= item;
      key_r     <= {item.left_glyph, item.right_glyph};
      bad_r     <= (item.left_glyph == '0) || (item.right_glyph == '0);
      sum_r     <= '0;
      sub_idx_r <= '0;
      red_r     <= PROBE_W'(item.slot);
      red_cnt_r <= RCW'(RED_STEPS);
    end else begin
      if (cmd.sub_next) begin
        sub_idx_r <= sub_idx_r + SIW'(1);
      end
      if (cmd.red_load) begin
        red_r     <= raw_c;
        red_cnt_r <= RCW'(RED_STEPS);
      end else if (cmd.red_step) begin
        if (red_ge) begin
          red_r <= red_r - red_sub[PROBE_W-1:0];
        end
        red_cnt_r <= red_k;
      end
      if (cmd.acc) begin
        sum_r <= d_ovr_r[cur] ? acc_v : sum_r + acc_v;
      end
    end
    if (cmd.srch_init) begin
      lo_r <= '0;
      hi_r <= $signed(15'(d_cnt_r[cur])) - 15'sd1;
    end else if (cmd.srch_upd) begin
      if (key_r < ram_rdata[ENTRY_W-1:VAL_W]) begin
        hi_r <= $signed({1'b0, mid_r}) - 15'sd1;
      end else begin
        lo_r <= $signed({1'b0, mid_r}) + 15'sd1;
      end
    end
    if (cmd.mid_load) begin
      mid_r <= mid_c;
    end
    if (cmd.desc_wr && (32'(it_r.slot) < 32'(MAX_SUBTABLES))) begin
      d_use_r[it_r.slot[SW-1:0]]   <= usable;
      d_ovr_r[it_r.slot[SW-1:0]]   <= it_r.coverage_word[3];
      d_first_r[it_r.slot[SW-1:0]] <= it_r.first_pair;
      d_cnt_r[it_r.slot[SW-1:0]]   <= it_r.pair_count;
    end
    if (cmd.out_load) begin
      kern_r <= sum_r;
      kbad_r <= bad_r;
    end
  end

  always_comb begin
    sts           = '0;
    sts.red_done  = (red_cnt_r == '0);
    sts.bad       = bad_r;
    sts.sub_end   = (5'(sub_idx_r) >= n_eff);
    sts.sub_use   = d_use_r[cur];
    sts.srch_open = (lo_r <= hi_r);
    sts.key_eq    = (key_r == ram_rdata[ENTRY_W-1:VAL_W]);
  end

  assign kerning   = kern_r;
  assign bad_glyph = kbad_r;
endmodule
`default_nettype wire

@@ rtl/kerning_pair_lookup.sv @@
`default_nettype none
// Channel  Direction  Signals                            Moves
// in       slave      in_tvalid in_tready in_tdata      one load or query item
//                     in_tuser
// out      master     out_tvalid out_tready out_tdata   one result item per query
//                     out_tuser
// cfg      slave      cfg_valid cfg_ready cfg_data      subtable count register
//
// One item is worked on at a time. A query's time grows with the subtables it
// consults, its search probes and its searched subtables that miss, and a finished
// query waits while an earlier result is still stalled in the output register.
// Each probe has an address state and a registered pair memory read; when
// PAIR_DEPTH is not a power of two, a pair load runs one reduction step per bit of
// the modulo reduction of the pair index and every probe runs those steps and one more.
// Reset is synchronous and needs no clearing pass; a finished result waits in
// the output register while the next item is accepted.
module kerning_pair_lookup #(
  parameter int PAIR_DEPTH    = 4096,
  parameter int MAX_SUBTABLES = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // slot, left_glyph, right_glyph, pair_value, coverage_word, first_pair,
  // pair_count, search_range_bytes, selector_log, range_shift_bytes, zero fill
  input  wire logic [kpl_pkg::IN_DATA_W-1:0]     in_tdata,
  // action
  input  wire logic [1:0]                        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // kerning
  output logic [kpl_pkg::OUT_DATA_W-1:0]         out_tdata,
  // bad_glyph
  output logic                                   out_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [kpl_pkg::CFG_W-1:0]         cfg_data
);
  import kpl_pkg::*;

  localparam int  RED_BITS  = $clog2(PROBE_MAX / PAIR_DEPTH + 1);
  localparam bit  DEPTH_P2  = ((PAIR_DEPTH & (PAIR_DEPTH - 1)) == 0);
  localparam int  RED_STEPS = DEPTH_P2 ? 0 : RED_BITS;

  kpl_item_t item;
  kpl_cmd_t  cmd;
  kpl_sts_t  sts;

  assign item.slot               = in_tdata[11:0];
  assign item.left_glyph         = in_tdata[27:12];
  assign item.right_glyph        = in_tdata[43:28];
  assign item.pair_value         = in_tdata[59:44];
  assign item.coverage_word      = in_tdata[75:60];
  assign item.first_pair         = in_tdata[87:76];
  assign item.pair_count         = in_tdata[100:88];
  assign item.search_range_bytes = in_tdata[116:101];
  assign item.selector_log       = in_tdata[120:117];
  assign item.range_shift_bytes  = in_tdata[136:121];

  assign cfg_ready = 1'b1;

  kpl_ctrl #(.DIRECT_ADDR(RED_STEPS == 0)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  kpl_dp #(
    .PAIR_DEPTH    (PAIR_DEPTH),
    .MAX_SUBTABLES (MAX_SUBTABLES),
    .RED_STEPS     (RED_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .kerning   (out_tdata),
    .bad_glyph (out_tuser)
  );

  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser != ACT_NONE)) |=> !in_tready)
    else $error("block took a new item while one was at work");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("zero glyph result carries a nonzero kerning");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without a query at work");
endmodule
`default_nettype wire
